FILE: design/rsd_pkg.sv
// Shared types, constants and helpers for the row SAD stereo disparity unit.
// No dependencies.
package rsd_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned DISP_W   = 6;
  localparam int unsigned COST_W   = 15;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned AGE_W    = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int unsigned COST_SAT = 32767;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic shift_px;
    logic acc_en;
    logic acc_clr;
    logic shift_acc;
  } rsd_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_RUN,
    S_MIN,
    S_OUT
  } rsd_state_e;

  function automatic logic [CHAN_W:0] abs_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] r;
    if (a > b) begin
      r = {1'b0, a} - {1'b0, b};
    end else begin
      r = {1'b0, b} - {1'b0, a};
    end
    return r;
  endfunction

  function automatic logic [CHAN_W+1:0] pix_sad(input pix_t a, input pix_t b);
    logic [CHAN_W+1:0] s;
    s = {1'b0, abs_diff(a.red, b.red)} + {1'b0, abs_diff(a.green, b.green)}
        + {1'b0, abs_diff(a.blue, b.blue)};
    return s;
  endfunction

endpackage

FILE: design/rsd_if.sv
// Valid/ready channel interfaces for pixel pairs and disparity results.
// Depends on rsd_pkg.
interface rsd_pix_if;
  import rsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] left_red;
  logic [CHAN_W-1:0] left_green;
  logic [CHAN_W-1:0] left_blue;
  logic [CHAN_W-1:0] right_red;
  logic [CHAN_W-1:0] right_green;
  logic [CHAN_W-1:0] right_blue;
  logic              row_end;
  modport source (output valid, left_red, left_green, left_blue, right_red, right_green,
                  right_blue, row_end, input ready);
  modport sink (input valid, left_red, left_green, left_blue, right_red, right_green,
                right_blue, row_end, output ready);
endinterface

interface rsd_res_if;
  import rsd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disparity;
  logic [COST_W-1:0]        match_cost;
  logic                     row_last;
  modport source (output valid, disparity, match_cost, row_last, input ready);
  modport sink (input valid, disparity, match_cost, row_last, output ready);
endinterface

FILE: design/rsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/rsd_cell.sv
// One candidate-shift cell: holds a right pixel and a running window cost.
// Depends on rsd_pkg.
module rsd_cell #(
  parameter int unsigned CW = 15
) (
  input  logic                    clk_i,
  input  rsd_pkg::rsd_cell_ctrl_t ctrl_i,
  input  rsd_pkg::pix_t           left_i,
  input  rsd_pkg::pix_t           r_i,
  output rsd_pkg::pix_t           r_o,
  input  logic [CW-1:0]           acc_i,
  output logic [CW-1:0]           acc_o
);
  import rsd_pkg::*;

  pix_t          r_q;
  logic [CW-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.shift_acc) begin
      acc_d = acc_i;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + CW'(pix_sad(left_i, r_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_px) begin
      r_q <= r_i;
    end
    acc_q <= acc_d;
  end

  assign r_o   = r_q;
  assign acc_o = acc_q;

endmodule

FILE: design/row_sad_stereo_disparity_unit.sv
// Row SAD stereo disparity: one left/right pixel pair per request.
// Each result streams the right row through the cell chain, then shifts the window costs out past
// the minimum compare; a request gives 0..WINDOW-1 results, and the block takes no new request
// until all of them have been delivered.
// Reset (async, active low) returns to idle with an empty row; no memory clearing pass.
module row_sad_stereo_disparity_unit #(
  parameter int unsigned WINDOW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsd_pix_if.sink     pix_i,
  rsd_res_if.source   res_o
);
  import rsd_pkg::*;

  localparam int unsigned PW = $clog2(2 * WINDOW);
  localparam int unsigned CW = $clog2(WINDOW * 765 + 1);
  localparam int unsigned DW = $clog2(WINDOW);
  localparam int unsigned TW = $clog2(2 * WINDOW + 1);

  rsd_state_e        state_q, state_d;
  logic [TW-1:0]     t_q, t_d;
  logic [DW-1:0]     d_q, d_d;
  logic              last_q, last_d;
  logic              main_q, main_d;
  logic              end_q, end_d;
  logic              flush_q, flush_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]     wp_q;
  logic              rd_q, a_q, lv_q;
  logic              issue, a_d;
  pix_t              l_q;
  logic [CW-1:0]     best_q, best_d;
  logic [DW-1:0]     bi_q, bi_d;
  logic              accept;
  logic [COUNT_W-1:0] cnt_inc;

  logic signed [AGE_W-1:0] age_r, age_l;
  logic [PW-1:0]     raddr_r, raddr_l;
  pix_t              wdata_l, wdata_r, rdata_l, rdata_r;
  rsd_cell_ctrl_t    cctrl;
  logic              clr;

  pix_t          r_chain [WINDOW+1];
  logic [CW-1:0] acc_chain [WINDOW+1];

  function automatic logic [PW-1:0] clamp_age(input logic signed [AGE_W-1:0] age,
                                              input logic [COUNT_W-1:0] cnt);
    logic [PW-1:0] r;
    if (age[AGE_W-1]) begin
      r = '0;
    end else if (age >= $signed({2'b00, cnt})) begin
      r = PW'(cnt - COUNT_W'(1));
    end else begin
      r = age[PW-1:0];
    end
    return r;
  endfunction

  assign accept  = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == S_IDLE);
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_W'(1);

  assign wdata_l = '{red: pix_i.left_red, green: pix_i.left_green, blue: pix_i.left_blue};
  assign wdata_r = '{red: pix_i.right_red, green: pix_i.right_green, blue: pix_i.right_blue};

  // right age walks down from d+WINDOW; left starts once the chain is full
  assign age_r = AGE_W'(d_q) + AGE_W'(WINDOW) - AGE_W'(t_q);
  assign age_l = AGE_W'(d_q) + AGE_W'(WINDOW / 2 + WINDOW - 1) - AGE_W'(t_q);
  assign raddr_r = wp_q - PW'(1) - clamp_age(age_r, cnt_q);
  assign raddr_l = wp_q - PW'(1) - clamp_age(age_l, cnt_q);

  rsd_ram #(.WIDTH($bits(pix_t)), .DEPTH(1 << PW)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (wdata_l),
    .raddr_i (raddr_l),
    .rdata_o (rdata_l)
  );

  rsd_ram #(.WIDTH($bits(pix_t)), .DEPTH(1 << PW)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (wdata_r),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  assign issue = (state_q == S_RUN) && (t_q < TW'(2 * WINDOW - 1));
  assign a_d   = issue && (t_q >= TW'(WINDOW - 1));

  assign cctrl.shift_px  = rd_q;
  assign cctrl.acc_en    = lv_q;
  assign cctrl.acc_clr   = clr;
  assign cctrl.shift_acc = (state_q == S_MIN);

  assign r_chain[WINDOW]   = rdata_r;
  assign acc_chain[WINDOW] = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rsd_cell #(.CW(CW)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctrl),
      .left_i (l_q),
      .r_i    (r_chain[i+1]),
      .r_o    (r_chain[i]),
      .acc_i  (acc_chain[i+1]),
      .acc_o  (acc_chain[i])
    );
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    d_d     = d_q;
    last_d  = last_q;
    main_d  = main_q;
    end_d   = end_q;
    flush_d = flush_q;
    cnt_d   = cnt_q;
    best_d  = best_q;
    bi_d    = bi_q;
    clr     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d   = cnt_inc;
          main_d  = (cnt_inc >= COUNT_W'(WINDOW - 1));
          end_d   = pix_i.row_end;
          flush_d = 1'b0;
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        t_d = '0;
        if (main_q) begin
          main_d  = 1'b0;
          d_d     = DW'(WINDOW - 2);
          last_d  = 1'b0;
          clr     = 1'b1;
          state_d = S_RUN;
        end else if (end_q) begin
          // flush starts at the oldest pixel still owed a result
          end_d   = 1'b0;
          flush_d = 1'b1;
          if ((cnt_q - COUNT_W'(1)) < COUNT_W'(WINDOW - 3)) begin
            d_d = DW'(cnt_q - COUNT_W'(1));
          end else begin
            d_d = DW'(WINDOW - 3);
          end
          last_d  = (d_d == '0);
          clr     = 1'b1;
          state_d = S_RUN;
        end else if (flush_q && (d_q != '0)) begin
          d_d     = d_q - DW'(1);
          last_d  = (d_d == '0);
          clr     = 1'b1;
          state_d = S_RUN;
        end else begin
          if (flush_q) begin
            cnt_d = '0;
          end
          flush_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (t_q == TW'(2 * WINDOW)) begin
          t_d     = '0;
          state_d = S_MIN;
        end else begin
          t_d = t_q + TW'(1);
        end
      end
      S_MIN: begin
        // strict compare keeps the first shift on a tie
        if ((t_q == '0) || (acc_chain[0] < best_q)) begin
          best_d = acc_chain[0];
          bi_d   = DW'(t_q);
        end
        if (t_q == TW'(WINDOW - 1)) begin
          state_d = S_OUT;
        end else begin
          t_d = t_q + TW'(1);
        end
      end
      S_OUT: begin
        if (res_o.ready) begin
          state_d = S_PICK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      t_q     <= '0;
      d_q     <= '0;
      last_q  <= 1'b0;
      main_q  <= 1'b0;
      end_q   <= 1'b0;
      flush_q <= 1'b0;
      cnt_q   <= '0;
      wp_q    <= '0;
      rd_q    <= 1'b0;
      a_q     <= 1'b0;
      lv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      d_q     <= d_d;
      last_q  <= last_d;
      main_q  <= main_d;
      end_q   <= end_d;
      flush_q <= flush_d;
      cnt_q   <= cnt_d;
      rd_q    <= issue;
      a_q     <= a_d;
      lv_q    <= a_q;
      if (accept) begin
        wp_q <= wp_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= rdata_l;
    best_q <= best_d;
    bi_q   <= bi_d;
  end

  logic signed [AGE_W-1:0] disp_full;

  assign disp_full = AGE_W'(WINDOW / 2) - AGE_W'(bi_q);

  assign res_o.valid = (state_q == S_OUT);
  assign res_o.row_last = last_q;
  always_comb begin
    if (disp_full > $signed(AGE_W'(31))) begin
      res_o.disparity = DISP_W'(31);
    end else if (disp_full < -$signed(AGE_W'(32))) begin
      res_o.disparity = DISP_W'(32);
    end else begin
      res_o.disparity = disp_full[DISP_W-1:0];
    end
    if (32'(best_q) > COST_SAT) begin
      res_o.match_cost = COST_W'(COST_SAT);
    end else begin
      res_o.match_cost = COST_W'(best_q);
    end
  end

endmodule

FILE: tb/tb_row_sad_stereo_disparity_unit.sv
// Self-checking bench for row_sad_stereo_disparity_unit: random rows of pixel pairs,
// a scoreboard that predicts disparity and match cost per pixel, and random backpressure.
// Depends on rsd_pkg, rsd_if and the unit itself.
module tb_row_sad_stereo_disparity_unit;
  import rsd_pkg::*;

  localparam int unsigned WINDOW = 32;
  localparam int unsigned HIST   = 2 * WINDOW;

  typedef struct {
    logic signed [DISP_W-1:0] disparity;
    logic [COST_W-1:0]        match_cost;
    logic                     row_last;
  } match_t;

  class disparity_scoreboard;
    pix_t         left_row[HIST];
    pix_t         right_row[HIST];
    int unsigned  seen_in_row;
    bit           row_opening;
    match_t       pending_matches[$];
    int unsigned  mismatches;

    function new();
      foreach (left_row[i]) begin
        left_row[i]  = '0;
        right_row[i] = '0;
      end
      seen_in_row = 0;
      row_opening = 1'b1;
      mismatches  = 0;
    endfunction

    function int unsigned chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function int unsigned pair_cost(pix_t a, pix_t b);
      return chan_gap(a.red, b.red) + chan_gap(a.green, b.green) + chan_gap(a.blue, b.blue);
    endfunction

    function int clamp_age(int age);
      if (age < 0) return 0;
      if (age >= int'(HIST)) return HIST - 1;
      return age;
    endfunction

    // best shift for the pixel sitting at age d in the row histories
    function void predict_match(int d, bit last);
      int unsigned cost, best_cost;
      int          best, disp;
      match_t      m;
      best      = -1;
      best_cost = 0;
      for (int i = 0; i < int'(WINDOW); i++) begin
        cost = 0;
        for (int k = 0; k < int'(WINDOW); k++)
          cost += pair_cost(left_row[clamp_age(d + WINDOW / 2 - k)],
                            right_row[clamp_age(d + WINDOW - i - k)]);
        if (best < 0 || cost < best_cost) begin
          best      = i;
          best_cost = cost;
        end
      end
      disp = WINDOW / 2 - best;
      if (disp > 31) disp = 31;
      if (disp < -32) disp = -32;
      if (best_cost > COST_SAT) best_cost = COST_SAT;
      m.disparity  = disp[DISP_W-1:0];
      m.match_cost = best_cost[COST_W-1:0];
      m.row_last   = last;
      pending_matches.push_back(m);
    endfunction

    function void note_pixel(pix_t lp, pix_t rp, bit row_end);
      int top;
      if (row_opening) begin
        foreach (left_row[i]) begin
          left_row[i]  = lp;
          right_row[i] = rp;
        end
        seen_in_row = 0;
        row_opening = 1'b0;
      end
      for (int i = HIST - 1; i > 0; i--) begin
        left_row[i]  = left_row[i-1];
        right_row[i] = right_row[i-1];
      end
      left_row[0]  = lp;
      right_row[0] = rp;
      if (seen_in_row < 127) seen_in_row++;
      if (seen_in_row >= WINDOW - 1) predict_match(WINDOW - 2, 1'b0);
      if (row_end) begin
        top = WINDOW - 3;
        if (int'(seen_in_row) - 1 < top) top = int'(seen_in_row) - 1;
        for (int d = top; d >= 0; d--) predict_match(d, d == 0);
        row_opening = 1'b1;
        seen_in_row = 0;
      end
    endfunction

    function void check_result(logic signed [DISP_W-1:0] disp, logic [COST_W-1:0] cost,
                               logic last);
      match_t m;
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result disp=%0d cost=%0d last=%0b", disp, cost, last);
        return;
      end
      m = pending_matches.pop_front();
      if (disp !== m.disparity || cost !== m.match_cost || last !== m.row_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch exp disp=%0d cost=%0d last=%0b, got %0d %0d %0b",
                   m.disparity, m.match_cost, m.row_last, disp, cost, last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rsd_pix_if pix ();
  rsd_res_if res ();

  row_sad_stereo_disparity_unit #(.WINDOW(WINDOW)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res)
  );

  disparity_scoreboard sboard = new();

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned pixels_sent;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    pix.valid       = 1'b0;
    pix.left_red    = '0;
    pix.left_green  = '0;
    pix.left_blue   = '0;
    pix.right_red   = '0;
    pix.right_green = '0;
    pix.right_blue  = '0;
    pix.row_end     = 1'b0;
    res.ready       = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_request && hold_left == 0) begin
      hold_left    = 3000;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready = 1'b0;
    end else begin
      res.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      sboard.check_result(res.disparity, res.match_cost, res.row_last);
  end

  task automatic send_pixel(pix_t lp, pix_t rp, bit row_end);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix.valid = 1'b0;
      @(negedge clk_i);
    end
    pix.valid       = 1'b1;
    pix.left_red    = lp.red;
    pix.left_green  = lp.green;
    pix.left_blue   = lp.blue;
    pix.right_red   = rp.red;
    pix.right_green = rp.green;
    pix.right_blue  = rp.blue;
    pix.row_end     = row_end;
    forever begin
      @(posedge clk_i);
      if (pix.ready) break;
    end
    sboard.note_pixel(lp, rp, row_end);
    pixels_sent++;
    @(negedge clk_i);
    pix.valid = 1'b0;
  endtask

  // row whose right image is the left one shifted by a random amount, with some noise
  task automatic send_row(int unsigned len, bit noisy);
    pix_t src[];
    pix_t lp, rp;
    int   shift;
    src   = new[len + 2 * WINDOW];
    shift = $urandom_range(2 * WINDOW - 1) - WINDOW;
    foreach (src[i]) src[i] = pix_t'(24'($urandom_range(24'hffffff)));
    for (int unsigned x = 0; x < len; x++) begin
      lp = src[x + WINDOW];
      rp = src[x + WINDOW + shift];
      if (noisy || $urandom_range(9) == 0) rp = pix_t'(24'($urandom_range(24'hffffff)));
      send_pixel(lp, rp, x == len - 1);
    end
  endtask

  task automatic set_phase(int unsigned ph);
    case (ph % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  initial begin
    int unsigned row_count;
    int unsigned fixed_lens[5];
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b0;
    hold_left       = 0;
    pixels_sent     = 0;
    fixed_lens      = '{30, 31, 32, 29, 1};
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes: single-pixel rows of full black against full white, then a two-pixel row of complements
    send_pixel(24'hffffff, 24'h000000, 1'b1);
    send_pixel(24'h000000, 24'hffffff, 1'b1);
    send_pixel(24'hff00ff, 24'h00ff00, 1'b0);
    send_pixel(24'h00ff00, 24'hff00ff, 1'b1);
    send_row(5, 1'b1);
    send_row(16, 1'b0);

    // one long row saturates the pixel count; hold the receiver during it
    set_phase(0);
    hold_request = 1'b1;
    send_row(135, 1'b0);
    hold_request = 1'b0;

    row_count = 0;
    while (pixels_sent < 260) begin
      set_phase(row_count);
      if (row_count < 5) send_row(fixed_lens[row_count], 1'b0);
      else send_row($urandom_range(1, 45), ($urandom_range(4) == 0));
      row_count++;
    end

    while (sboard.pending_matches.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sboard.mismatches == 0 && sboard.pending_matches.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
design/rsd_pkg.sv
design/rsd_if.sv
design/rsd_ram.sv
design/rsd_cell.sv
design/row_sad_stereo_disparity_unit.sv
tb/tb_row_sad_stereo_disparity_unit.sv
